// ===== src/ufd_pkg.sv =====
// ----------------------------------------------------------------------------
// ufd_pkg: shared types and constants of the URL form decoder
// Character codes, result kinds, the result entry type and the hex helpers.
// ----------------------------------------------------------------------------
package ufd_pkg;

	// Body characters with a meaning of their own
	localparam logic [7:0] CH_PCT   = 8'h25;  // '%'
	localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
	localparam logic [7:0] CH_AMP   = 8'h26;  // '&'
	localparam logic [7:0] CH_EQ    = 8'h3D;  // '='
	localparam logic [7:0] CH_SPACE = 8'h20;

	// Input action codes
	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_END  = 1'b1;

	// Result kinds
	localparam logic [1:0] KIND_NAME  = 2'd0;
	localparam logic [1:0] KIND_VALUE = 2'd1;
	localparam logic [1:0] KIND_FEND  = 2'd2;
	localparam logic [1:0] KIND_BEND  = 2'd3;

	// Escape phases
	localparam logic [1:0] ESC_NONE  = 2'd0;
	localparam logic [1:0] ESC_PCT   = 2'd1;
	localparam logic [1:0] ESC_DIGIT = 2'd2;

	localparam int unsigned MAX_RESULTS = 4;
	localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);
	localparam int unsigned IDX_W       = $clog2(MAX_RESULTS);
	localparam int unsigned FIELD_W     = 6;

	typedef struct packed {
		logic [1:0]         kind;
		logic [7:0]         out_byte;
		logic [FIELD_W-1:0] field_index;
		logic               has_value;
	} result_t;

	// '+' decodes to a space, everything else passes as is
	function automatic logic [7:0] plain_char(input logic [7:0] c);
		plain_char = (c == CH_PLUS) ? CH_SPACE : c;
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
			(c >= 8'h41 && c <= 8'h46);
	endfunction

	function automatic logic [3:0] hex_nibble(input logic [7:0] c);
		logic [7:0] v;
		v = 8'h00;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = c - 8'h30;
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = c - 8'h57;
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = c - 8'h37;
		end
		hex_nibble = v[3:0];
	endfunction

	// Bad first digit gives 0; bad second digit keeps the first digit's value
	function automatic logic [7:0] hex_combine(input logic [7:0] hi, input logic [7:0] lo);
		logic [7:0] r;
		r = 8'h00;
		if (is_hex(hi)) begin
			if (is_hex(lo)) begin
				r = {hex_nibble(hi), hex_nibble(lo)};
			end else begin
				r = {4'h0, hex_nibble(hi)};
			end
		end
		hex_combine = r;
	endfunction

endpackage

// ===== src/url_form_decoder.sv =====
// ----------------------------------------------------------------------------
// url_form_decoder: URL-encoded form body decoder
// Splits a form body on '&', splits each pair at its first '=', decodes '+'
// and %XX escapes and emits tagged name, value, field-end and body-end items.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  tdata: body_byte; tuser: action
// m_*      out  m_tvalid/m_tready  tdata: out_byte, field_index, has_value;
//                                  tuser: kind; tlast: last
//
// An input item is decoded in the cycle it is accepted; its zero to four
// result items are loaded into a four-entry result register and drained one
// per cycle. A new item is taken whenever that register is empty or holds
// only its final entry which leaves in the same cycle, so a body whose items
// give at most one result each runs at one item per cycle; else a new item
// waits for the last result. arst_n clears the parse state and empties the
// result register. A stall on m_* holds the results and back-pressures s_*.
module url_form_decoder #(
	parameter int MAX_FIELDS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] body_byte
	input  logic        s_tuser,   // [0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] out_byte, [13:8] field_index,
	                               // [14] has_value, [15] zero
	output logic [1:0]  m_tuser,   // [1:0] kind
	output logic        m_tlast
);

	localparam int unsigned FW = ufd_pkg::FIELD_W;
	// fields_q is six bits wide, so the limit stops at 63
	localparam logic [FW-1:0] FIELD_LIMIT =
		(MAX_FIELDS > 63) ? FW'(63) : FW'(MAX_FIELDS);

	// Parse state
	logic [1:0]    esc_q;
	logic [7:0]    held_q;
	logic          inval_q;
	logic          open_q;
	logic [FW-1:0] fields_q;

	// Result register, entry 0 is the one on the port
	ufd_pkg::result_t res_q [ufd_pkg::MAX_RESULTS];
	logic [ufd_pkg::CNT_W-1:0] cnt_q;

	// Next state and new results
	logic [1:0]    esc_d;
	logic [7:0]    held_d;
	logic          inval_d;
	logic          open_d;
	logic [FW-1:0] fields_d;
	ufd_pkg::result_t res_d [ufd_pkg::MAX_RESULTS];
	logic [ufd_pkg::CNT_W-1:0] cnt_d;

	logic [7:0] c;
	logic       s_fire;
	logic       m_fire;

	assign c        = s_tdata;
	assign m_tvalid = (cnt_q != '0);
	assign m_fire   = m_tvalid && m_tready;
	// Take a new item once the last pending result leaves
	assign s_tready = (cnt_q == '0) ||
		((cnt_q == ufd_pkg::CNT_W'(1)) && m_tready);
	assign s_fire   = s_tvalid && s_tready;

	assign m_tdata = {1'b0, res_q[0].has_value, res_q[0].field_index, res_q[0].out_byte};
	assign m_tuser = res_q[0].kind;
	assign m_tlast = (cnt_q == ufd_pkg::CNT_W'(1));

	// Decode one item: build its results in order and the state it leaves
	always_comb begin
		logic          flush_pct;
		logic          flush_held;
		logic          main_en;
		logic [7:0]    main_byte;
		logic          fend_en;
		logic          bend_en;
		logic [1:0]    eff_esc;
		logic [7:0]    eff_held;
		logic          eff_inval;
		logic          skip;
		logic [1:0]    part_kind;
		logic [FW-1:0] bend_idx;

		flush_pct  = 1'b0;
		flush_held = 1'b0;
		main_en    = 1'b0;
		main_byte  = 8'h00;
		fend_en    = 1'b0;
		bend_en    = 1'b0;
		bend_idx   = fields_q;

		esc_d    = esc_q;
		held_d   = held_q;
		inval_d  = inval_q;
		open_d   = open_q;
		fields_d = fields_q;

		// A closed field opens with a clean escape and name part
		eff_esc   = open_q ? esc_q : ufd_pkg::ESC_NONE;
		eff_held  = open_q ? held_q : 8'h00;
		eff_inval = open_q ? inval_q : 1'b0;
		skip      = 1'b0;

		if (s_tuser == ufd_pkg::ACT_END) begin
			if (open_q) begin
				flush_pct  = (esc_q == ufd_pkg::ESC_PCT) || (esc_q == ufd_pkg::ESC_DIGIT);
				flush_held = (esc_q == ufd_pkg::ESC_DIGIT);
				fend_en    = 1'b1;
				bend_idx   = fields_q + FW'(1);
			end
			bend_en  = 1'b1;
			esc_d    = ufd_pkg::ESC_NONE;
			held_d   = 8'h00;
			inval_d  = 1'b0;
			open_d   = 1'b0;
			fields_d = '0;
		end else begin
			skip = !open_q && ((c == ufd_pkg::CH_AMP) || (fields_q >= FIELD_LIMIT));
			if (!skip) begin
				open_d  = 1'b1;
				inval_d = eff_inval;
				esc_d   = eff_esc;
				held_d  = eff_held;
				if (c == ufd_pkg::CH_AMP) begin
					flush_pct  = (eff_esc == ufd_pkg::ESC_PCT) ||
						(eff_esc == ufd_pkg::ESC_DIGIT);
					flush_held = (eff_esc == ufd_pkg::ESC_DIGIT);
					fend_en    = 1'b1;
					fields_d   = fields_q + FW'(1);
					open_d     = 1'b0;
					inval_d    = 1'b0;
					esc_d      = ufd_pkg::ESC_NONE;
					held_d     = 8'h00;
				end else if ((c == ufd_pkg::CH_EQ) && !eff_inval) begin
					flush_pct  = (eff_esc == ufd_pkg::ESC_PCT) ||
						(eff_esc == ufd_pkg::ESC_DIGIT);
					flush_held = (eff_esc == ufd_pkg::ESC_DIGIT);
					inval_d    = 1'b1;
					esc_d      = ufd_pkg::ESC_NONE;
					held_d     = 8'h00;
				end else if (eff_esc == ufd_pkg::ESC_NONE) begin
					if (c == ufd_pkg::CH_PCT) begin
						esc_d = ufd_pkg::ESC_PCT;
					end else begin
						main_en   = 1'b1;
						main_byte = ufd_pkg::plain_char(c);
					end
				end else if (eff_esc == ufd_pkg::ESC_PCT) begin
					held_d = c;
					esc_d  = ufd_pkg::ESC_DIGIT;
				end else begin
					main_en   = 1'b1;
					main_byte = ufd_pkg::hex_combine(eff_held, c);
					esc_d     = ufd_pkg::ESC_NONE;
					held_d    = 8'h00;
				end
			end
		end

		// Name or value bytes follow the part that was open before this item
		part_kind = (s_tuser == ufd_pkg::ACT_END) ?
			(inval_q ? ufd_pkg::KIND_VALUE : ufd_pkg::KIND_NAME) :
			(eff_inval ? ufd_pkg::KIND_VALUE : ufd_pkg::KIND_NAME);

		// Pack the enabled results in order
		for (int i = 0; i < ufd_pkg::MAX_RESULTS; i++) begin
			res_d[i] = '{ufd_pkg::KIND_NAME, 8'h00, '0, 1'b0};
		end
		cnt_d = '0;
		if (flush_pct) begin
			res_d[cnt_d[ufd_pkg::IDX_W-1:0]] = '{part_kind, ufd_pkg::CH_PCT, fields_q, 1'b0};
			cnt_d = cnt_d + ufd_pkg::CNT_W'(1);
		end
		if (flush_held) begin
			res_d[cnt_d[ufd_pkg::IDX_W-1:0]] =
				'{part_kind, ufd_pkg::plain_char(eff_held), fields_q, 1'b0};
			cnt_d = cnt_d + ufd_pkg::CNT_W'(1);
		end
		if (main_en) begin
			res_d[cnt_d[ufd_pkg::IDX_W-1:0]] = '{part_kind, main_byte, fields_q, 1'b0};
			cnt_d = cnt_d + ufd_pkg::CNT_W'(1);
		end
		if (fend_en) begin
			res_d[cnt_d[ufd_pkg::IDX_W-1:0]] =
				'{ufd_pkg::KIND_FEND, 8'h00, fields_q, eff_inval};
			cnt_d = cnt_d + ufd_pkg::CNT_W'(1);
		end
		if (bend_en) begin
			res_d[cnt_d[ufd_pkg::IDX_W-1:0]] = '{ufd_pkg::KIND_BEND, 8'h00, bend_idx, 1'b0};
			cnt_d = cnt_d + ufd_pkg::CNT_W'(1);
		end
	end

	// Parse state advances on every accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q    <= ufd_pkg::ESC_NONE;
			held_q   <= 8'h00;
			inval_q  <= 1'b0;
			open_q   <= 1'b0;
			fields_q <= '0;
		end else if (s_fire) begin
			esc_q    <= esc_d;
			held_q   <= held_d;
			inval_q  <= inval_d;
			open_q   <= open_d;
			fields_q <= fields_d;
		end
	end

	// Result count: load on accept, count down as items leave
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (s_fire) begin
			cnt_q <= cnt_d;
		end else if (m_fire) begin
			cnt_q <= cnt_q - ufd_pkg::CNT_W'(1);
		end
	end

	// Result entries: load on accept, shift toward the port as items leave
	always_ff @(posedge clk) begin
		if (s_fire) begin
			for (int i = 0; i < ufd_pkg::MAX_RESULTS; i++) begin
				res_q[i] <= res_d[i];
			end
		end else if (m_fire) begin
			for (int i = 0; i < ufd_pkg::MAX_RESULTS - 1; i++) begin
				res_q[i] <= res_q[i+1];
			end
		end
	end

endmodule
